>>> rtl/core/oust_pkg.sv
// Shared types for the ordered unique set table: request codes, states, command and status.
package oust_pkg;

    typedef enum logic [2:0] {
        REQ_INSERT   = 3'd0,
        REQ_REMOVE   = 3'd1,
        REQ_CONTAINS = 3'd2,
        REQ_FIRST    = 3'd3,
        REQ_NEXT     = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SHIFT_INS,
        ST_SHIFT_REM,
        ST_READ_WAIT
    } t_state;

    typedef enum logic [1:0] {
        RA_CUR,
        RA_CUR_M1,
        RA_ZERO,
        RA_POS_P1
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    search_step;
        logic    ins_init;
        logic    ins_step;
        logic    rem_init;
        logic    rem_step;
        logic    shift_wr;
        logic    front_wr;
        logic    dec_count;
        t_rd_sel rd_sel;
        logic    res_valid;
        logic    res_ok;
        logic    res_full;
        logic    res_use_data;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic hit_now;
        logic pvld;
        logic found;
        logic cur_zero;
        logic cur_end;
        logic full;
        logic empty;
        logic next_ok;
    } t_status;

endpackage

>>> rtl/core/oust_dp.sv
// Datapath of the ordered unique set table: key memory, cursor, count and result registers.
module oust_dp #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_req_type,
    input  logic signed [31:0] i_key,
    input  oust_pkg::t_cmd    i_cmd,
    output oust_pkg::t_status o_status,
    output logic              o_done,
    output logic              o_ok,
    output logic              o_full_res,
    output logic signed [31:0] o_value
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic [31:0]     mem [CAPACITY];

    oust_pkg::t_req  r_req;
    logic [31:0]     r_key;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_cur;
    logic [CW-1:0]   r_pidx;
    logic            r_pvld;
    logic [CW-1:0]   r_pos;
    logic            r_found;
    logic [31:0]     r_rdata;
    logic            r_done;
    logic            r_ok;
    logic            r_full;
    logic [31:0]     r_value;

    logic [CW-1:0]   pos_p1;
    logic [CW-1:0]   rd_idx;
    logic            hit_now;
    logic            cur_end;
    logic            cur_zero;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [31:0]     wr_data;

    assign pos_p1   = r_pos + CW'(1);
    assign hit_now  = r_pvld && (r_rdata == r_key);
    assign cur_end  = (r_cur >= r_count);
    assign cur_zero = (r_cur == '0);

    always_comb begin
        unique case (i_cmd.rd_sel)
            oust_pkg::RA_CUR:    rd_idx = r_cur;
            oust_pkg::RA_CUR_M1: rd_idx = r_cur - CW'(1);
            oust_pkg::RA_ZERO:   rd_idx = '0;
            oust_pkg::RA_POS_P1: rd_idx = pos_p1;
            default:             rd_idx = r_cur;
        endcase
    end

    // Shift moves copy the word read in the previous cycle to the slot tagged with it.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pidx[AW-1:0];
        wr_data = r_rdata;
        if (i_cmd.shift_wr && r_pvld) begin
            wr_en = 1'b1;
        end else if (i_cmd.front_wr) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_idx[AW-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pvld  <= 1'b0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.res_valid;
            if (i_cmd.load) begin
                r_pvld  <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.search_step) begin
                if (hit_now) begin
                    r_found <= 1'b1;
                end
                r_pvld <= !cur_end;
            end else if (i_cmd.ins_init || i_cmd.rem_init) begin
                r_pvld <= 1'b0;
            end else if (i_cmd.ins_step) begin
                r_pvld <= !cur_zero;
            end else if (i_cmd.rem_step) begin
                r_pvld <= !cur_end;
            end
            if (i_cmd.front_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= oust_pkg::t_req'(i_req_type);
            r_key <= i_key;
            r_cur <= '0;
        end else if (i_cmd.search_step) begin
            if (hit_now) begin
                r_pos <= r_pidx;
            end
            r_pidx <= r_cur;
            if (!cur_end) begin
                r_cur <= r_cur + CW'(1);
            end
        end else if (i_cmd.ins_init) begin
            r_cur <= r_count;
        end else if (i_cmd.rem_init) begin
            r_cur <= pos_p1;
        end else if (i_cmd.ins_step) begin
            if (!cur_zero) begin
                r_pidx <= r_cur;
                r_cur  <= r_cur - CW'(1);
            end
        end else if (i_cmd.rem_step) begin
            if (!cur_end) begin
                r_pidx <= r_cur - CW'(1);
                r_cur  <= r_cur + CW'(1);
            end
        end
        if (i_cmd.res_valid) begin
            r_ok    <= i_cmd.res_ok;
            r_full  <= i_cmd.res_full;
            r_value <= i_cmd.res_use_data ? r_rdata : '0;
        end
    end

    assign o_status.req      = r_req;
    assign o_status.hit_now  = hit_now;
    assign o_status.pvld     = r_pvld;
    assign o_status.found    = r_found;
    assign o_status.cur_zero = cur_zero;
    assign o_status.cur_end  = cur_end;
    assign o_status.full     = (r_count == CW'(CAPACITY));
    assign o_status.empty    = (r_count == '0);
    assign o_status.next_ok  = (pos_p1 < r_count);

    assign o_done     = r_done;
    assign o_ok       = r_ok;
    assign o_full_res = r_full;
    assign o_value    = r_value;

endmodule

>>> rtl/core/oust_ctrl.sv
// Controller of the ordered unique set table: sequences search, shift and read phases.
module oust_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  oust_pkg::t_status i_status,
    output logic              busy,
    output oust_pkg::t_cmd    o_cmd
);

    oust_pkg::t_state r_state;
    oust_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oust_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oust_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = oust_pkg::ST_SEARCH;
                end
            end
            oust_pkg::ST_SEARCH: begin
                if (i_status.hit_now || (i_status.cur_end && !i_status.pvld)) begin
                    n_state = oust_pkg::ST_DECIDE;
                end
            end
            oust_pkg::ST_DECIDE: begin
                n_state = oust_pkg::ST_IDLE;
                unique case (i_status.req)
                    oust_pkg::REQ_INSERT: begin
                        if (!i_status.found && !i_status.full) begin
                            n_state = oust_pkg::ST_SHIFT_INS;
                        end
                    end
                    oust_pkg::REQ_REMOVE: begin
                        if (i_status.found) begin
                            n_state = oust_pkg::ST_SHIFT_REM;
                        end
                    end
                    oust_pkg::REQ_FIRST: begin
                        if (!i_status.empty) begin
                            n_state = oust_pkg::ST_READ_WAIT;
                        end
                    end
                    oust_pkg::REQ_NEXT: begin
                        if (i_status.found && i_status.next_ok) begin
                            n_state = oust_pkg::ST_READ_WAIT;
                        end
                    end
                    default: n_state = oust_pkg::ST_IDLE;
                endcase
            end
            oust_pkg::ST_SHIFT_INS: begin
                if (i_status.cur_zero && !i_status.pvld) begin
                    n_state = oust_pkg::ST_IDLE;
                end
            end
            oust_pkg::ST_SHIFT_REM: begin
                if (i_status.cur_end && !i_status.pvld) begin
                    n_state = oust_pkg::ST_IDLE;
                end
            end
            oust_pkg::ST_READ_WAIT: n_state = oust_pkg::ST_IDLE;
            default:                n_state = oust_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = oust_pkg::RA_CUR;
        unique case (r_state)
            oust_pkg::ST_IDLE: begin
                o_cmd.load = start;
            end
            oust_pkg::ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
            end
            oust_pkg::ST_DECIDE: begin
                unique case (i_status.req)
                    oust_pkg::REQ_INSERT: begin
                        if (i_status.found) begin
                            o_cmd.res_valid = 1'b1;
                        end else if (i_status.full) begin
                            o_cmd.res_valid = 1'b1;
                            o_cmd.res_full  = 1'b1;
                        end else begin
                            o_cmd.ins_init = 1'b1;
                        end
                    end
                    oust_pkg::REQ_REMOVE: begin
                        if (i_status.found) begin
                            o_cmd.rem_init = 1'b1;
                        end else begin
                            o_cmd.res_valid = 1'b1;
                        end
                    end
                    oust_pkg::REQ_CONTAINS: begin
                        o_cmd.res_valid = 1'b1;
                        o_cmd.res_ok    = i_status.found;
                    end
                    oust_pkg::REQ_FIRST: begin
                        o_cmd.rd_sel    = oust_pkg::RA_ZERO;
                        o_cmd.res_valid = i_status.empty;
                    end
                    oust_pkg::REQ_NEXT: begin
                        o_cmd.rd_sel    = oust_pkg::RA_POS_P1;
                        o_cmd.res_valid = !(i_status.found && i_status.next_ok);
                    end
                    default: o_cmd.res_valid = 1'b1;
                endcase
            end
            oust_pkg::ST_SHIFT_INS: begin
                o_cmd.rd_sel   = oust_pkg::RA_CUR_M1;
                o_cmd.ins_step = 1'b1;
                o_cmd.shift_wr = 1'b1;
                if (i_status.cur_zero && !i_status.pvld) begin
                    o_cmd.front_wr  = 1'b1;
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_ok    = 1'b1;
                end
            end
            oust_pkg::ST_SHIFT_REM: begin
                o_cmd.rem_step = 1'b1;
                o_cmd.shift_wr = 1'b1;
                if (i_status.cur_end && !i_status.pvld) begin
                    o_cmd.dec_count = 1'b1;
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_ok    = 1'b1;
                end
            end
            oust_pkg::ST_READ_WAIT: begin
                o_cmd.res_valid    = 1'b1;
                o_cmd.res_ok       = 1'b1;
                o_cmd.res_use_data = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != oust_pkg::ST_IDLE);

endmodule

>>> rtl/core/ordered_unique_set_table.sv
// Top level of the ordered unique set table: controller and datapath.
// Usage: a request (i_req_type, i_key) is taken at a rising edge where start is
// high and busy is low. busy stays high while the request is worked on. Each
// request yields one result on o_ok, o_full_res and o_value, shown for exactly
// one cycle with o_done high; the receiver cannot stall it. busy falls in the
// cycle that o_done is high, so the next request may start with that edge.
// A search reads one table slot per cycle through the single read port of the key
// memory and is followed by a decision state. An insert then moves every live key
// back one slot, and a remove closes the gap; first and next add a read state.
// The keys are compared as 32-bit patterns.
// Reset clears the key count, so the table is empty; the key memory itself is
// not cleared, since only live slots are read. Unused request codes give
// ok = 0 and change nothing.
module ordered_unique_set_table #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_key,
    output logic               o_done,
    output logic               o_ok,
    output logic               o_full_res,
    output logic signed [31:0] o_value
);

    oust_pkg::t_cmd    cmd;
    oust_pkg::t_status status;

    oust_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    oust_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_done     (o_done),
        .o_ok       (o_ok),
        .o_full_res (o_full_res),
        .o_value    (o_value)
    );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the ordered unique set table, with directed and random requests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 64;
    localparam int POOL_SIZE   = 96;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 20;

    // Request codes the block does not define.
    localparam logic [2:0] REQ_RSVD5 = 3'd5;
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    localparam logic [31:0] KEY_MIN = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_NEG = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        ok;
        logic        full_res;
        logic [31:0] value;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_req_type = '0;
    logic signed [31:0] i_key = '0;
    logic               o_done;
    logic               o_ok;
    logic               o_full_res;
    logic signed [31:0] o_value;

    // Shadow copy of the table, updated when a request is accepted.
    logic [31:0] shadow_keys [CAPACITY];
    int          shadow_count = 0;

    t_outcome    pending_outcomes [$];
    logic [31:0] key_pool [POOL_SIZE];

    int  fail_count = 0;
    int  results_checked = 0;
    int  full_refusals = 0;
    int  req_seen [8];
    int  cycle_count = 0;
    bit  idle_bursts_on = 1'b1;

    ordered_unique_set_table #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_req_type(i_req_type),
        .i_key     (i_key),
        .o_done    (o_done),
        .o_ok      (o_ok),
        .o_full_res(o_full_res),
        .o_value   (o_value)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Applies one request to the shadow table and returns the result it must give.
    function automatic t_outcome apply_set_op(logic [2:0] req, logic [31:0] k);
        t_outcome r;
        int       pos;
        int       i;
        r = '0;
        pos = shadow_count;
        for (i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] == k) begin
                pos = i;
                break;
            end
        end
        case (req)
            oust_pkg::REQ_INSERT: begin
                if (pos < shadow_count) begin
                    r.ok = 1'b0;
                end else if (shadow_count >= CAPACITY) begin
                    r.full_res = 1'b1;
                end else begin
                    for (i = shadow_count; i > 0; i--)
                        shadow_keys[i] = shadow_keys[i - 1];
                    shadow_keys[0] = k;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            oust_pkg::REQ_REMOVE: begin
                if (pos < shadow_count) begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_keys[i] = shadow_keys[i + 1];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            oust_pkg::REQ_CONTAINS: r.ok = (pos < shadow_count);
            oust_pkg::REQ_FIRST: begin
                if (shadow_count > 0) begin
                    r.ok = 1'b1;
                    r.value = shadow_keys[0];
                end
            end
            oust_pkg::REQ_NEXT: begin
                if (pos + 1 < shadow_count) begin
                    r.ok = 1'b1;
                    r.value = shadow_keys[pos + 1];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Results are compared at the edge that accepts them; requests are predicted at the
    // edge that accepts them. Doing both here keeps the queue order independent of races.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $error("Result with no request waiting: ok=%b full_res=%b value=%h",
                       o_ok, o_full_res, o_value);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (o_ok !== want.ok) begin
                    $error("ok: expected %b, got %b", want.ok, o_ok);
                    fail_count++;
                end
                if (o_full_res !== want.full_res) begin
                    $error("full_res: expected %b, got %b", want.full_res, o_full_res);
                    fail_count++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, o_value);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            want = apply_set_op(i_req_type, i_key);
            if (want.full_res)
                full_refusals++;
            req_seen[i_req_type]++;
            pending_outcomes.push_back(want);
        end
    end

    // Sends one request. start is left high on return so that the next request can be
    // taken at the very edge where the block finishes; wait_all_done lowers it.
    task automatic send_req(logic [2:0] req, logic [31:0] k);
        if (idle_bursts_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= req;
        i_key      <= k;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    // The first edge lets the transaction accepted at the previous edge reach the queue.
    task automatic wait_all_done();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_outcomes.size() != 0);
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (sel < 85 && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        return $urandom();
    endfunction

    task automatic test_empty_table();
        send_req(oust_pkg::REQ_FIRST, $urandom());
        send_req(oust_pkg::REQ_NEXT, 32'd0);
        send_req(oust_pkg::REQ_REMOVE, KEY_MIN);
        send_req(oust_pkg::REQ_CONTAINS, 32'd0);
        wait_all_done();
    endtask

    task automatic test_extreme_keys();
        send_req(oust_pkg::REQ_INSERT, KEY_MIN);
        send_req(oust_pkg::REQ_INSERT, KEY_MAX);
        send_req(oust_pkg::REQ_INSERT, 32'd0);
        send_req(oust_pkg::REQ_INSERT, KEY_NEG);
        send_req(oust_pkg::REQ_INSERT, KEY_MIN);          // already present
        send_req(oust_pkg::REQ_FIRST, KEY_MAX);
        send_req(oust_pkg::REQ_NEXT, KEY_NEG);
        send_req(oust_pkg::REQ_NEXT, KEY_MIN);            // oldest key has no successor
        send_req(oust_pkg::REQ_CONTAINS, KEY_MAX);
        send_req(oust_pkg::REQ_REMOVE, 32'd0);
        send_req(oust_pkg::REQ_REMOVE, 32'd0);
        send_req(oust_pkg::REQ_NEXT, KEY_NEG);
        wait_all_done();
    endtask

    task automatic test_unused_codes();
        send_req(REQ_RSVD5, KEY_MAX);
        send_req(REQ_RSVD6, KEY_NEG);
        send_req(REQ_RSVD7, $urandom());
        send_req(oust_pkg::REQ_CONTAINS, KEY_MAX);
        wait_all_done();
    endtask

    task automatic test_fill_to_capacity();
        logic [31:0] base;
        logic [31:0] fill_keys [CAPACITY];
        int          i;
        int          j;
        logic [31:0] tmp;
        base = $urandom();
        for (i = 0; i < CAPACITY; i++)
            fill_keys[i] = base + i * 32'd7919;
        // Whatever remains from earlier tests is cleared first.
        while (shadow_count > 0) begin
            send_req(oust_pkg::REQ_REMOVE, shadow_keys[0]);
        end
        for (i = 0; i < CAPACITY; i++)
            send_req(oust_pkg::REQ_INSERT, fill_keys[i]);
        send_req(oust_pkg::REQ_INSERT, base - 32'd1);     // absent key into a full table
        send_req(oust_pkg::REQ_INSERT, fill_keys[5]);     // duplicate into a full table
        send_req(oust_pkg::REQ_NEXT, fill_keys[0]);
        send_req(oust_pkg::REQ_FIRST, 32'd0);
        send_req(oust_pkg::REQ_CONTAINS, fill_keys[CAPACITY - 1]);
        send_req(oust_pkg::REQ_REMOVE, fill_keys[CAPACITY / 2]);
        send_req(oust_pkg::REQ_INSERT, base - 32'd1);
        send_req(oust_pkg::REQ_INSERT, fill_keys[CAPACITY / 2]);
        fill_keys[CAPACITY / 2] = base - 32'd1;
        for (i = CAPACITY - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = fill_keys[i];
            fill_keys[i] = fill_keys[j];
            fill_keys[j] = tmp;
        end
        for (i = 0; i < CAPACITY; i++) begin
            send_req(oust_pkg::REQ_REMOVE, fill_keys[i]);
            if (i % 16 == 0)
                send_req(oust_pkg::REQ_NEXT, shadow_count > 0 ? shadow_keys[0] : 32'd0);
        end
        send_req(oust_pkg::REQ_FIRST, 32'd0);
        wait_all_done();
    endtask

    // Thresholds are cumulative percentages; what is left over goes to unused codes.
    task automatic run_random_phase(int n, int t_ins, int t_rem, int t_con, int t_first,
                                    int t_next);
        int          sel;
        logic [2:0]  req;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < t_ins)
                req = oust_pkg::REQ_INSERT;
            else if (sel < t_rem)
                req = oust_pkg::REQ_REMOVE;
            else if (sel < t_con)
                req = oust_pkg::REQ_CONTAINS;
            else if (sel < t_first)
                req = oust_pkg::REQ_FIRST;
            else if (sel < t_next)
                req = oust_pkg::REQ_NEXT;
            else
                req = 3'($urandom_range(REQ_RSVD5, REQ_RSVD7));
            send_req(req, pick_key());
        end
        wait_all_done();
    endtask

    task automatic test_random_traffic();
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'd0;
        key_pool[3] = KEY_NEG;
        run_random_phase(350, 35, 55, 70, 80, 97);
        run_random_phase(400, 60, 68, 80, 86, 98);   // pushes the table to capacity
        run_random_phase(300, 15, 60, 72, 80, 97);   // drains it again
        run_random_phase(350, 30, 45, 65, 75, 97);
        idle_bursts_on = 1'b0;
        run_random_phase(250, 40, 60, 72, 80, 97);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_extreme_keys();
        test_unused_codes();
        test_fill_to_capacity();
        test_random_traffic();
        wait_all_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d results never arrived", pending_outcomes.size());
            fail_count++;
        end
        $display("Checked %0d results: %0d insert, %0d remove, %0d contains, %0d first,",
                 results_checked, req_seen[oust_pkg::REQ_INSERT],
                 req_seen[oust_pkg::REQ_REMOVE], req_seen[oust_pkg::REQ_CONTAINS],
                 req_seen[oust_pkg::REQ_FIRST]);
        $display("%0d next, %0d unused-code requests; %0d inserts refused on a full table.",
                 req_seen[oust_pkg::REQ_NEXT], req_seen[REQ_RSVD5] + req_seen[REQ_RSVD6] +
                 req_seen[REQ_RSVD7], full_refusals);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/oust_pkg.sv
rtl/core/oust_dp.sv
rtl/core/oust_ctrl.sv
rtl/core/ordered_unique_set_table.sv
tb/sv/tb_top.sv
